/* sv/twsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package twsc_pkg;

  localparam int TIME_W = 48;
  localparam int TICK_W = 16;
  localparam int PER_W  = 32;
  localparam int ID_W   = 5;
  localparam int OP_W   = 2;
  localparam int PEND_W = 6;

  localparam int DEF_WHEEL_SLOTS = 64;
  localparam int DEF_TIMER_COUNT = 32;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd10;
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              id_ok;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] arr;
    logic              rep;
    logic [PER_W-1:0]  period;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/twsc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module twsc_front #(
  parameter int TIMER_COUNT = twsc_pkg::DEF_TIMER_COUNT
) (
  input  wire logic                        start,
  input  wire logic [twsc_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [twsc_pkg::ID_W-1:0]   in_timer_id,
  input  wire logic [twsc_pkg::TIME_W-1:0] in_time_now,
  input  wire logic [twsc_pkg::TIME_W-1:0] in_arrival_time,
  input  wire logic                        in_repeating,
  input  wire logic [twsc_pkg::PER_W-1:0]  in_period_ms,
  input  wire logic                        q_full,
  output logic                             busy,
  output logic                             q_push,
  output twsc_pkg::cmd_t                   q_wdata
);
  import twsc_pkg::*;

  // ids beyond the pool are flagged here and ignored by the back end
  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_wdata.op     = in_opcode;
    q_wdata.id     = in_timer_id;
    q_wdata.id_ok  = (32'(in_timer_id) < 32'(TIMER_COUNT));
    q_wdata.now    = in_time_now;
    q_wdata.arr    = in_arrival_time;
    q_wdata.rep    = in_repeating;
    q_wdata.period = in_period_ms;
  end

endmodule
`default_nettype wire

/* sv/twsc_cmdq.sv */
`timescale 1ns / 1ps
`default_nettype none
module twsc_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire twsc_pkg::cmd_t wdata,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output twsc_pkg::cmd_t      rdata
);
  import twsc_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CNTW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            mem_r [CMDQ_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            do_pop;

  assign full   = (cnt_r == CNTW'(CMDQ_DEPTH));
  assign valid  = (cnt_r != '0);
  assign rdata  = mem_r[rp_r];
  assign do_pop = pop && valid;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CNTW'(push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("command pushed into full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(CMDQ_DEPTH)) else $error("command queue count out of range");
`endif

endmodule
`default_nettype wire

/* sv/twsc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module twsc_div #(
  parameter int QB = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [QB+twsc_pkg::TICK_W-1:0]     dividend,
  input  wire logic [twsc_pkg::TICK_W-1:0]        divisor,
  output logic                                    done,
  output logic [QB-1:0]                           quot
);
  import twsc_pkg::*;

  localparam int DVW = QB + TICK_W;
  localparam int SW  = (QB > 1) ? $clog2(QB) : 1;

  logic           run_r, run_nxt, done_r, done_nxt;
  logic [DVW-1:0] rem_r, rem_nxt, trial;
  logic [QB-1:0]  q_r, q_nxt;
  logic [SW-1:0]  step_r, step_nxt;

  assign done  = done_r;
  assign quot  = q_r;
  assign trial = DVW'(divisor) << step_r;

  // restoring division, one quotient bit a cycle, msb first
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    if (start) begin
      run_nxt  = 1'b1;
      rem_nxt  = dividend;
      q_nxt    = '0;
      step_nxt = SW'(QB - 1);
    end else if (run_r) begin
      if (rem_r >= trial) begin
        rem_nxt       = rem_r - trial;
        q_nxt[step_r] = 1'b1;
      end
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

endmodule
`default_nettype wire

/* sv/twsc_exec.sv */
`timescale 1ns / 1ps
`default_nettype none
module twsc_exec #(
  parameter int WHEEL_SLOTS = twsc_pkg::DEF_WHEEL_SLOTS,
  parameter int TIMER_COUNT = twsc_pkg::DEF_TIMER_COUNT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire twsc_pkg::cmd_t              q_rdata,
  output logic                             q_pop,
  input  wire logic [twsc_pkg::TICK_W-1:0] tick,
  output logic                             out_strobe,
  output logic [twsc_pkg::ID_W-1:0]        out_expired_id,
  output logic                             out_expired_valid,
  output logic [twsc_pkg::TIME_W-1:0]      out_wait_ms,
  output logic                             out_wait_valid,
  output logic [twsc_pkg::PEND_W-1:0]      out_pending_total,
  output logic                             out_final_res
);
  import twsc_pkg::*;

  localparam int QW  = $clog2(WHEEL_SLOTS);
  localparam int QB  = QW + 1;
  localparam int DVW = QB + TICK_W;
  localparam int IW  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW  = $clog2(TIMER_COUNT + 1);
  localparam int TC  = TIMER_COUNT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_CAN   = 4'd2;
  localparam logic [3:0] S_PLACE = 4'd3;
  localparam logic [3:0] S_PDIV  = 4'd4;
  localparam logic [3:0] S_ADV   = 4'd5;
  localparam logic [3:0] S_ADIV  = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_OSCAN = 4'd8;
  localparam logic [3:0] S_OPICK = 4'd9;
  localparam logic [3:0] S_REARM = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_QRY   = 4'd12;
  localparam logic [3:0] S_QSCAN = 4'd13;
  localparam logic [3:0] S_QMUL  = 4'd14;
  localparam logic [3:0] S_QOUT  = 4'd15;

  localparam logic RET_ADD   = 1'b0;
  localparam logic RET_REARM = 1'b1;

  logic [3:0]        state_r, state_nxt;
  logic              ret_r, ret_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [QW-1:0]     pos_r, pos_nxt;
  logic [TC-1:0]     wheel_v_r, wheel_v_nxt, ovf_v_r, ovf_v_nxt;
  logic [TC-1:0]     cancel_r, cancel_nxt, rep_r, rep_nxt;
  logic [CW-1:0]     pend_r, pend_nxt, nf_r, nf_nxt, k_r, k_nxt;
  logic [QB-1:0]     t_r, t_nxt, ticks_r, ticks_nxt;
  logic [IW-1:0]     j_r, j_nxt, best_r, best_nxt, pl_idx_r, pl_idx_nxt;
  logic              found_r, found_nxt, have_w_r, have_w_nxt, have_o_r, have_o_nxt;
  logic [TIME_W-1:0] best_arr_r, best_arr_nxt, pl_arr_r, pl_arr_nxt;
  logic [QW-1:0]     mind_r, mind_nxt;
  logic [TIME_W-1:0] mino_r, mino_nxt, until_r, until_nxt, wwait_r, wwait_nxt;
  logic [TIME_W-1:0] wait_r, wait_nxt;
  logic              wvalid_r, wvalid_nxt;

  logic              ostb_r, ostb_nxt, oev_r, oev_nxt, owv_r, owv_nxt, ofin_r, ofin_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [TIME_W-1:0] owait_r, owait_nxt;

  // stores: per-id wheel slot, overflow arrival and period, and the fired list
  logic [QW-1:0]     slot_idx_r [TC];
  logic [TIME_W-1:0] ovf_arr_r  [TC];
  logic [PER_W-1:0]  period_r   [TC];
  logic [IW-1:0]     fire_r     [TC];

  logic              slot_we, ovf_we, per_we, fire_we;
  logic [IW-1:0]     slot_wa, ovf_wa, per_wa;
  logic [QW-1:0]     slot_wd;
  logic [TIME_W-1:0] ovf_wd;
  logic [PER_W-1:0]  per_wd;
  logic [IW-1:0]     fire_wd;

  logic              div_start, div_done;
  logic [DVW-1:0]    div_dividend;
  logic [QB-1:0]     div_quot;

  logic [DVW-1:0]    span, span_adv, qt, mt;
  logic [TIME_W:0]   pl_diff, at_sum;
  logic [TIME_W-1:0] pl_d, el, elc, at, arr_j, ow, last_adv;
  logic              pl_near, due_j;
  logic [TC-1:0]     members;
  logic [IW-1:0]     low;
  logic [QW+1:0]     slot_sum, slot_gap_w;
  logic [QW-1:0]     new_slot, slot_gap;
  logic [IW-1:0]     fk;

  twsc_div #(.QB(QB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (tick),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign span     = DVW'(WHEEL_SLOTS) * DVW'(tick);
  assign span_adv = DVW'(WHEEL_SLOTS + 1) * DVW'(tick);
  assign qt       = DVW'(div_quot) * DVW'(tick);
  assign mt       = DVW'(mind_r) * DVW'(tick);
  assign last_adv = last_r + TIME_W'(qt);

  assign pl_diff = {1'b0, pl_arr_r} - {1'b0, cmd_r.now};
  assign pl_d    = (pl_diff[TIME_W] || pl_diff == '0) ? TIME_W'(tick) : pl_diff[TIME_W-1:0];
  assign pl_near = (pl_d <= TIME_W'(span));

  assign el  = (cmd_r.now > last_r) ? cmd_r.now - last_r : '0;
  assign elc = (el > TIME_W'(tick)) ? TIME_W'(tick) : el;

  assign arr_j = ovf_arr_r[j_r];
  assign due_j = ovf_v_r[j_r] && (arr_j <= cmd_r.now);
  assign ow    = (arr_j > cmd_r.now) ? arr_j - cmd_r.now : '0;

  assign fk     = fire_r[k_r[IW-1:0]];
  assign at_sum = {1'b0, cmd_r.now} + (TIME_W+1)'(period_r[fk]);
  assign at     = at_sum[TIME_W] ? TIME_MAX : at_sum[TIME_W-1:0];

  assign slot_sum = (QW+2)'(pos_r) + (QW+2)'(div_quot);
  assign new_slot = (slot_sum >= (QW+2)'(WHEEL_SLOTS)) ?
                    QW'(slot_sum - (QW+2)'(WHEEL_SLOTS)) : QW'(slot_sum);

  assign slot_gap_w = (slot_idx_r[j_r] >= pos_r) ?
                      (QW+2)'(slot_idx_r[j_r]) - (QW+2)'(pos_r) :
                      (QW+2)'(slot_idx_r[j_r]) + (QW+2)'(WHEEL_SLOTS) - (QW+2)'(pos_r);
  assign slot_gap   = QW'(slot_gap_w);

  // ids held in the slot under the wheel position, lowest first
  always_comb begin
    low = '0;
    for (int i = 0; i < TC; i++) begin
      members[i] = wheel_v_r[i] && (slot_idx_r[i] == pos_r);
    end
    for (int i = TC - 1; i >= 0; i--) begin
      if (members[i]) begin
        low = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    last_nxt     = last_r;
    pos_nxt      = pos_r;
    wheel_v_nxt  = wheel_v_r;
    ovf_v_nxt    = ovf_v_r;
    cancel_nxt   = cancel_r;
    rep_nxt      = rep_r;
    pend_nxt     = pend_r;
    nf_nxt       = nf_r;
    k_nxt        = k_r;
    t_nxt        = t_r;
    ticks_nxt    = ticks_r;
    j_nxt        = j_r;
    best_nxt     = best_r;
    pl_idx_nxt   = pl_idx_r;
    found_nxt    = found_r;
    have_w_nxt   = have_w_r;
    have_o_nxt   = have_o_r;
    best_arr_nxt = best_arr_r;
    pl_arr_nxt   = pl_arr_r;
    mind_nxt     = mind_r;
    mino_nxt     = mino_r;
    until_nxt    = until_r;
    wwait_nxt    = wwait_r;
    wait_nxt     = wait_r;
    wvalid_nxt   = wvalid_r;
    ostb_nxt     = 1'b0;
    oid_nxt      = oid_r;
    oev_nxt      = oev_r;
    owait_nxt    = owait_r;
    owv_nxt      = owv_r;
    ofin_nxt     = ofin_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    slot_we      = 1'b0;
    slot_wa      = pl_idx_r;
    slot_wd      = new_slot;
    ovf_we       = 1'b0;
    ovf_wa       = pl_idx_r;
    ovf_wd       = pl_arr_r;
    per_we       = 1'b0;
    per_wa       = idx_r;
    per_wd       = cmd_r.period;
    fire_we      = 1'b0;
    fire_wd      = low;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_rdata;
          idx_nxt    = IW'(q_rdata.id);
          nf_nxt     = '0;
          k_nxt      = '0;
          wait_nxt   = '0;
          wvalid_nxt = 1'b0;
          unique case (q_rdata.op)
            OP_ADD:     state_nxt = S_ADD;
            OP_CANCEL:  state_nxt = S_CAN;
            OP_ADVANCE: state_nxt = S_ADV;
            OP_QUERY:   state_nxt = S_QRY;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end

      S_ADD: begin
        if (cmd_r.id_ok) begin
          if (last_r == '0) begin
            last_nxt = cmd_r.now;
          end
          // drop the old placement, clear the cancel mark
          if (wheel_v_r[idx_r] || ovf_v_r[idx_r]) begin
            pend_nxt = pend_r - 1'b1;
          end
          wheel_v_nxt[idx_r] = 1'b0;
          ovf_v_nxt[idx_r]   = 1'b0;
          cancel_nxt[idx_r]  = 1'b0;
          rep_nxt[idx_r]     = cmd_r.rep;
          per_we             = 1'b1;
          pl_idx_nxt         = idx_r;
          pl_arr_nxt         = cmd_r.arr;
          ret_nxt            = RET_ADD;
          state_nxt          = S_PLACE;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_CAN: begin
        if (cmd_r.id_ok) begin
          cancel_nxt[idx_r] = 1'b1;
        end
        state_nxt = S_EMIT;
      end

      S_PLACE: begin
        if (pl_near) begin
          div_start    = 1'b1;
          div_dividend = DVW'(pl_d - 1'b1);
          state_nxt    = S_PDIV;
        end else begin
          ovf_we              = 1'b1;
          ovf_v_nxt[pl_idx_r] = 1'b1;
          pend_nxt            = pend_r + 1'b1;
          if (ret_r == RET_REARM) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_REARM;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_PDIV: begin
        if (div_done) begin
          slot_we               = 1'b1;
          wheel_v_nxt[pl_idx_r] = 1'b1;
          pend_nxt              = pend_r + 1'b1;
          if (ret_r == RET_REARM) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_REARM;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_ADV: begin
        t_nxt = '0;
        if (last_r == '0) begin
          last_nxt  = cmd_r.now;
          state_nxt = S_EMIT;
        end else if (el >= TIME_W'(span_adv)) begin
          ticks_nxt = QB'(WHEEL_SLOTS);
          last_nxt  = cmd_r.now;
          state_nxt = S_WALK;
        end else begin
          div_start    = 1'b1;
          div_dividend = DVW'(el);
          state_nxt    = S_ADIV;
        end
      end

      S_ADIV: begin
        if (div_done) begin
          ticks_nxt = div_quot;
          last_nxt  = last_adv;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (t_r == ticks_r) begin
          j_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_OSCAN;
        end else if (members == '0) begin
          pos_nxt = (pos_r == QW'(WHEEL_SLOTS - 1)) ? '0 : pos_r + 1'b1;
          t_nxt   = t_r + 1'b1;
        end else begin
          wheel_v_nxt[low] = 1'b0;
          pend_nxt         = pend_r - 1'b1;
          if (!cancel_r[low]) begin
            fire_we = 1'b1;
            nf_nxt  = nf_r + 1'b1;
          end
        end
      end

      S_OSCAN: begin
        if (due_j && (!found_r || arr_j < best_arr_r)) begin
          found_nxt    = 1'b1;
          best_nxt     = j_r;
          best_arr_nxt = arr_j;
        end
        if (j_r == IW'(TC - 1)) begin
          state_nxt = S_OPICK;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      S_OPICK: begin
        if (!found_r) begin
          k_nxt     = '0;
          state_nxt = S_REARM;
        end else begin
          ovf_v_nxt[best_r] = 1'b0;
          pend_nxt          = pend_r - 1'b1;
          if (!cancel_r[best_r]) begin
            fire_we = 1'b1;
            fire_wd = best_r;
            nf_nxt  = nf_r + 1'b1;
          end
          found_nxt = 1'b0;
          j_nxt     = '0;
          state_nxt = S_OSCAN;
        end
      end

      S_REARM: begin
        if (k_r == nf_r) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else if (rep_r[fk]) begin
          pl_idx_nxt = fk;
          pl_arr_nxt = at;
          ret_nxt    = RET_REARM;
          state_nxt  = S_PLACE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_QRY: begin
        until_nxt  = (last_r == '0) ? TIME_W'(tick) :
                     ((TIME_W'(tick) == elc) ? TIME_W'(1) : TIME_W'(tick) - elc);
        j_nxt      = '0;
        have_w_nxt = 1'b0;
        have_o_nxt = 1'b0;
        state_nxt  = S_QSCAN;
      end

      S_QSCAN: begin
        if (wheel_v_r[j_r] && (!have_w_r || slot_gap < mind_r)) begin
          have_w_nxt = 1'b1;
          mind_nxt   = slot_gap;
        end
        if (ovf_v_r[j_r] && (!have_o_r || ow < mino_r)) begin
          have_o_nxt = 1'b1;
          mino_nxt   = ow;
        end
        if (j_r == IW'(TC - 1)) begin
          state_nxt = S_QMUL;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      S_QMUL: begin
        wwait_nxt = until_r + TIME_W'(mt);
        state_nxt = S_QOUT;
      end

      S_QOUT: begin
        wvalid_nxt = have_w_r || have_o_r;
        if (have_o_r && (!have_w_r || mino_r < wwait_r)) begin
          wait_nxt = mino_r;
        end else if (have_w_r) begin
          wait_nxt = wwait_r;
        end else begin
          wait_nxt = '0;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        ostb_nxt = 1'b1;
        if (k_r < nf_r) begin
          oid_nxt   = ID_W'(fk);
          oev_nxt   = 1'b1;
          owait_nxt = '0;
          owv_nxt   = 1'b0;
          ofin_nxt  = 1'b0;
          k_nxt     = k_r + 1'b1;
        end else begin
          oid_nxt   = '0;
          oev_nxt   = 1'b0;
          owait_nxt = wait_r;
          owv_nxt   = wvalid_r;
          ofin_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      last_r    <= '0;
      pos_r     <= '0;
      wheel_v_r <= '0;
      ovf_v_r   <= '0;
      cancel_r  <= '0;
      rep_r     <= '0;
      pend_r    <= '0;
      nf_r      <= '0;
      k_r       <= '0;
      ostb_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      last_r    <= last_nxt;
      pos_r     <= pos_nxt;
      wheel_v_r <= wheel_v_nxt;
      ovf_v_r   <= ovf_v_nxt;
      cancel_r  <= cancel_nxt;
      rep_r     <= rep_nxt;
      pend_r    <= pend_nxt;
      nf_r      <= nf_nxt;
      k_r       <= k_nxt;
      ostb_r    <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    t_r        <= t_nxt;
    ticks_r    <= ticks_nxt;
    j_r        <= j_nxt;
    best_r     <= best_nxt;
    pl_idx_r   <= pl_idx_nxt;
    found_r    <= found_nxt;
    have_w_r   <= have_w_nxt;
    have_o_r   <= have_o_nxt;
    best_arr_r <= best_arr_nxt;
    pl_arr_r   <= pl_arr_nxt;
    mind_r     <= mind_nxt;
    mino_r     <= mino_nxt;
    until_r    <= until_nxt;
    wwait_r    <= wwait_nxt;
    wait_r     <= wait_nxt;
    wvalid_r   <= wvalid_nxt;
    oid_r      <= oid_nxt;
    oev_r      <= oev_nxt;
    owait_r    <= owait_nxt;
    owv_r      <= owv_nxt;
    ofin_r     <= ofin_nxt;
    if (slot_we) begin
      slot_idx_r[slot_wa] <= slot_wd;
    end
    if (ovf_we) begin
      ovf_arr_r[ovf_wa] <= ovf_wd;
    end
    if (per_we) begin
      period_r[per_wa] <= per_wd;
    end
    if (fire_we) begin
      fire_r[nf_r[IW-1:0]] <= fire_wd;
    end
  end

  assign out_strobe        = ostb_r;
  assign out_expired_id    = oid_r;
  assign out_expired_valid = oev_r;
  assign out_wait_ms       = owait_r;
  assign out_wait_valid    = owv_r;
  assign out_pending_total = PEND_W'(pend_r);
  assign out_final_res     = ofin_r;

`ifndef SYNTH
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == CW'($countones(wheel_v_r | ovf_v_r)))
    else $error("pending count out of step with placements");
  a_one_place: assert property (@(posedge clk) disable iff (!rst_n)
    (wheel_v_r & ovf_v_r) == '0) else $error("timer held in wheel and overflow");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    ostb_nxt |-> state_r == S_EMIT) else $error("result beat outside emit");
`endif

endmodule
`default_nettype wire

/* sv/timer_wheel_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Timer wheel scheduler: a pool of TIMER_COUNT timers on a WHEEL_SLOTS-slot
// wheel with an overflow set for far timers. Commands enter on start while
// busy is low into a two-entry command queue, so up to two commands can be
// waiting while one executes; busy rises only when that queue is full.
// Results leave one beat per cycle on out_strobe and must be taken as they
// come: the receiver cannot stall. Commands run one at a time in the single
// sequencer in the back end, which shares one bit-serial divider
// (Q = clog2(WHEEL_SLOTS) + 1 steps) between placement and advance. An
// advance walks the passed ticks, clearing each timer held in a passed slot
// and firing it unless cancelled, then takes the due overflow entries,
// earliest first, then re-arms each repeating timer that fired, then sends
// its result beats. tick_length_ms is written on the cfg channel, which is
// always ready; write it only when the block is idle. A tick of 0 acts as 1.
module timer_wheel_scheduler_top #(
  parameter int WHEEL_SLOTS = twsc_pkg::DEF_WHEEL_SLOTS,
  parameter int TIMER_COUNT = twsc_pkg::DEF_TIMER_COUNT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [twsc_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [twsc_pkg::ID_W-1:0]   in_timer_id,
  input  wire logic [twsc_pkg::TIME_W-1:0] in_time_now,
  input  wire logic [twsc_pkg::TIME_W-1:0] in_arrival_time,
  input  wire logic                        in_repeating,
  input  wire logic [twsc_pkg::PER_W-1:0]  in_period_ms,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [twsc_pkg::TICK_W-1:0] cfg_tick_length_ms,
  output logic                             out_strobe,
  output logic [twsc_pkg::ID_W-1:0]        out_expired_id,
  output logic                             out_expired_valid,
  output logic [twsc_pkg::TIME_W-1:0]      out_wait_ms,
  output logic                             out_wait_valid,
  output logic [twsc_pkg::PEND_W-1:0]      out_pending_total,
  output logic                             out_final_res
);
  import twsc_pkg::*;

  logic [TICK_W-1:0] tick_r, tick_nxt, tick_eff;
  logic              q_full, q_push, q_valid, q_pop;
  cmd_t              q_wdata, q_rdata;

  // tick register: always ready, hold between writes
  assign cfg_ready = 1'b1;
  assign tick_nxt  = cfg_valid ? cfg_tick_length_ms : tick_r;
  assign tick_eff  = (tick_r == '0) ? TICK_W'(1) : tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_RESET;
    end else begin
      tick_r <= tick_nxt;
    end
  end

  // front: take the beat and flag ids outside the pool
  twsc_front #(.TIMER_COUNT(TIMER_COUNT)) u_front (
    .start           (start),
    .in_opcode       (in_opcode),
    .in_timer_id     (in_timer_id),
    .in_time_now     (in_time_now),
    .in_arrival_time (in_arrival_time),
    .in_repeating    (in_repeating),
    .in_period_ms    (in_period_ms),
    .q_full          (q_full),
    .busy            (busy),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  // queue: decouple command intake from execution
  twsc_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // back end: wheel, overflow, firing, re-arm and result beats
  twsc_exec #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .TIMER_COUNT (TIMER_COUNT)
  ) u_exec (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .tick              (tick_eff),
    .out_strobe        (out_strobe),
    .out_expired_id    (out_expired_id),
    .out_expired_valid (out_expired_valid),
    .out_wait_ms       (out_wait_ms),
    .out_wait_valid    (out_wait_valid),
    .out_pending_total (out_pending_total),
    .out_final_res     (out_final_res)
  );

endmodule
`default_nettype wire

/* sim/timer_wheel_scheduler_top_tb.sv */
`timescale 1ns / 1ps
module timer_wheel_scheduler_top_tb;
  import twsc_pkg::*;

  localparam int  SLOTS     = DEF_WHEEL_SLOTS;
  localparam int  TIMERS    = DEF_TIMER_COUNT;
  localparam int  CYC_LIMIT = 1000000;
  localparam longint unsigned T_MAX = 64'hFFFF_FFFF_FFFF;

  // One command as the sender presents it.
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] arr;
    logic              rep;
    logic [PER_W-1:0]  per;
  } stim_t;

  // One result beat.
  typedef struct {
    logic [ID_W-1:0]   id;
    logic              ev;
    logic [TIME_W-1:0] wait_ms;
    logic              wv;
    logic [PEND_W-1:0] pend;
    logic              fin;
  } beat_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_opcode;
  logic [ID_W-1:0]     in_timer_id;
  logic [TIME_W-1:0]   in_time_now;
  logic [TIME_W-1:0]   in_arrival_time;
  logic                in_repeating;
  logic [PER_W-1:0]    in_period_ms;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TICK_W-1:0]   cfg_tick_length_ms;
  logic                out_strobe;
  logic [ID_W-1:0]     out_expired_id;
  logic                out_expired_valid;
  logic [TIME_W-1:0]   out_wait_ms;
  logic                out_wait_valid;
  logic [PEND_W-1:0]   out_pending_total;
  logic                out_final_res;

  timer_wheel_scheduler_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_timer_id(in_timer_id), .in_time_now(in_time_now),
    .in_arrival_time(in_arrival_time), .in_repeating(in_repeating),
    .in_period_ms(in_period_ms),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_tick_length_ms(cfg_tick_length_ms),
    .out_strobe(out_strobe), .out_expired_id(out_expired_id),
    .out_expired_valid(out_expired_valid), .out_wait_ms(out_wait_ms),
    .out_wait_valid(out_wait_valid), .out_pending_total(out_pending_total),
    .out_final_res(out_final_res)
  );

  // Commands waiting for the driver, and beats waiting for the monitor.
  stim_t cmd_q[$];
  beat_t beat_q[$];
  int    errors;
  int    cycles;
  int    send_idle_pct;
  longint unsigned tnow;   // time cursor of the stimulus

  // Shadow copy of the scheduler state.
  logic [TIMERS-1:0] slot_ids [SLOTS];
  int                wpos;
  longint unsigned   last_t;
  logic [TIMERS-1:0] ovf_v, cancel_m, rep_m;
  longint unsigned   ovf_at [TIMERS];
  longint unsigned   per_of [TIMERS];
  logic [TICK_W-1:0] tick_reg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned tick_ms();
    return (tick_reg == 0) ? 64'd1 : longint'(tick_reg);
  endfunction

  function automatic int held_count();
    int c;
    c = $countones(ovf_v);
    for (int s = 0; s < SLOTS; s++) c += $countones(slot_ids[s]);
    return c;
  endfunction

  function automatic void drop_timer(int id);
    for (int s = 0; s < SLOTS; s++) slot_ids[s][id] = 1'b0;
    ovf_v[id] = 1'b0;
  endfunction

  // Put a timer on the wheel, or in the overflow set when it lies beyond the wheel range.
  function automatic void place_timer(int id, longint unsigned arr, longint unsigned now);
    longint tk, delay;
    tk = longint'(tick_ms());
    delay = longint'(arr) - longint'(now);
    if (delay <= 0) delay = tk;
    if (delay <= SLOTS * tk) slot_ids[(wpos + (delay - 1) / tk) % SLOTS][id] = 1'b1;
    else begin
      ovf_v[id] = 1'b1;
      ovf_at[id] = arr & T_MAX;
    end
  endfunction

  function automatic void push_beat(int id, bit ev, longint unsigned w, bit wv, bit fin);
    beat_t b;
    b.id = ID_W'(id);
    b.ev = ev;
    b.wait_ms = TIME_W'(w);
    b.wv = wv;
    b.pend = PEND_W'(held_count());
    b.fin = fin;
    beat_q.insert(beat_q.size(), b);
  endfunction

  // Work out the beats that one accepted command causes, and update the shadow state.
  function automatic void schedule_cmd(stim_t c);
    longint unsigned tk, now, elapsed, ticks, at, best, until_t, w;
    int              fired[$];
    int              pick;
    bit              have;
    tk = tick_ms();
    now = c.now;
    case (c.op)
      OP_ADD: begin
        if (last_t == 0) last_t = now;
        drop_timer(c.id);
        cancel_m[c.id] = 1'b0;
        rep_m[c.id] = c.rep;
        per_of[c.id] = c.per;
        place_timer(c.id, c.arr, now);
        push_beat(0, 0, 0, 0, 1);
      end
      OP_CANCEL: begin
        cancel_m[c.id] = 1'b1;
        push_beat(0, 0, 0, 0, 1);
      end
      OP_ADVANCE: begin
        if (last_t == 0) last_t = now;
        else begin
          elapsed = (now > last_t) ? now - last_t : 0;
          ticks = elapsed / tk;
          if (ticks > SLOTS) begin
            ticks = SLOTS;
            last_t = now;
          end else last_t += ticks * tk;
          // sweep the passed slots, ascending ids within each
          for (longint unsigned t = 0; t < ticks; t++) begin
            for (int i = 0; i < TIMERS; i++)
              if (slot_ids[wpos][i] && !cancel_m[i] && fired.size() < TIMERS)
                fired.insert(fired.size(), i);
            slot_ids[wpos] = '0;
            wpos = (wpos + 1) % SLOTS;
          end
          // then due overflow entries, earliest arrival first, lower id on a tie
          forever begin
            pick = -1;
            for (int i = 0; i < TIMERS; i++)
              if (ovf_v[i] && ovf_at[i] <= now && (pick < 0 || ovf_at[i] < ovf_at[pick]))
                pick = i;
            if (pick < 0) break;
            ovf_v[pick] = 1'b0;
            if (!cancel_m[pick] && fired.size() < TIMERS) fired.insert(fired.size(), pick);
          end
          // re-arm repeating timers, saturating at the top of the time range
          foreach (fired[k])
            if (rep_m[fired[k]]) begin
              at = now + per_of[fired[k]];
              if (at > T_MAX) at = T_MAX;
              drop_timer(fired[k]);
              place_timer(fired[k], at, now);
            end
        end
        foreach (fired[k]) push_beat(fired[k], 1, 0, 0, 0);
        push_beat(0, 0, 0, 0, 1);
      end
      default: begin
        elapsed = (last_t != 0 && now > last_t) ? now - last_t : 0;
        if (elapsed > tk) elapsed = tk;
        until_t = tk - elapsed;
        if (until_t < 1) until_t = 1;
        have = 0;
        best = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_ids[(wpos + i) % SLOTS] != 0) begin
            best = until_t + i * tk;
            have = 1;
            break;
          end
        for (int i = 0; i < TIMERS; i++)
          if (ovf_v[i]) begin
            w = (ovf_at[i] > now) ? ovf_at[i] - now : 0;
            if (!have || w < best) begin
              best = w;
              have = 1;
            end
          end
        push_beat(0, 0, have ? best : 0, have, 1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Driver: hold start with a command until it is taken, then move on or idle.
  always @(posedge clk) begin : driver
    stim_t c;
    if (!rst_n) start <= 1'b0;
    else begin
      if (start && !busy) schedule_cmd('{in_opcode, in_timer_id, in_time_now,
                                         in_arrival_time, in_repeating, in_period_ms});
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_q.pop_front();
          in_opcode       <= c.op;
          in_timer_id     <= c.id;
          in_time_now     <= c.now;
          in_arrival_time <= c.arr;
          in_repeating    <= c.rep;
          in_period_ms    <= c.per;
          start           <= 1'b1;
        end else start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must meet the oldest expectation; also guard the run length.
  always @(posedge clk) begin : monitor
    beat_t e;
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n && out_strobe) begin
      if (beat_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        e = beat_q.pop_front();
        if (out_expired_id !== e.id) report_mismatch("expired_id", out_expired_id, e.id);
        if (out_expired_valid !== e.ev)
          report_mismatch("expired_valid", out_expired_valid, e.ev);
        if (out_wait_ms !== e.wait_ms) report_mismatch("wait_ms", out_wait_ms, e.wait_ms);
        if (out_wait_valid !== e.wv) report_mismatch("wait_valid", out_wait_valid, e.wv);
        if (out_pending_total !== e.pend)
          report_mismatch("pending_total", out_pending_total, e.pend);
        if (out_final_res !== e.fin) report_mismatch("final_res", out_final_res, e.fin);
      end
    end
  end

  function automatic void add_cmd(logic [OP_W-1:0] op, int id, longint unsigned now,
                                  longint unsigned arr, bit rep, longint unsigned per);
    stim_t c;
    c = '{op, id[ID_W-1:0], now[TIME_W-1:0], arr[TIME_W-1:0], rep, per[PER_W-1:0]};
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  // Random command around the time cursor, scaled to the current tick.
  function automatic void random_cmd();
    longint unsigned tk, arr, per;
    int r;
    tk = tick_ms();
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(5))
        0:       arr = tnow - $urandom_range(0, 50);            // already due
        1:       arr = tnow + tk * SLOTS + $urandom_range(0, 3); // at the wheel edge
        2:       arr = tnow + tk * $urandom_range(SLOTS, 4 * SLOTS); // overflow
        3:       arr = {$urandom, $urandom} & T_MAX;            // anywhere
        default: arr = tnow + $urandom_range(0, 20) * tk + $urandom_range(0, tk);
      endcase
      case ($urandom_range(3))
        0:       per = 0;
        1:       per = $urandom;
        default: per = $urandom_range(1, 10) * tk;
      endcase
      add_cmd(OP_ADD, $urandom_range(TIMERS - 1), tnow, arr, $urandom_range(1), per);
    end else if (r < 50) begin
      add_cmd(OP_CANCEL, $urandom_range(TIMERS - 1), tnow, $urandom, 0, $urandom);
    end else if (r < 80) begin
      case ($urandom_range(9))
        0:       tnow = tnow - $urandom_range(0, tk);           // clock steps back
        1:       tnow = tnow + tk * $urandom_range(SLOTS + 1, 3 * SLOTS); // long gap
        default: tnow = tnow + $urandom_range(0, 8 * tk);
      endcase
      add_cmd(OP_ADVANCE, $urandom_range(TIMERS - 1), tnow, $urandom, 0, 0);
    end else begin
      add_cmd(OP_QUERY, $urandom_range(TIMERS - 1), tnow + $urandom_range(0, 2 * tk), 0, 0, 0);
    end
  endfunction

  // Wait until every command is taken and every beat has arrived, then let the block settle.
  task automatic drain();
    do @(posedge clk); while (cmd_q.size() != 0 || start || beat_q.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_tick(input logic [TICK_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_tick_length_ms <= v;
    do @(posedge clk); while (!cfg_ready);
    tick_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [TICK_W-1:0] tk, input int pct, input int n);
    write_tick(tk);
    send_idle_pct = pct;
    repeat (n) random_cmd();
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    send_idle_pct = 9;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_QUERY;
    in_timer_id = '0;
    in_time_now = '0;
    in_arrival_time = '0;
    in_repeating = 1'b0;
    in_period_ms = '0;
    cfg_valid = 1'b0;
    cfg_tick_length_ms = '0;
    tick_reg = TICK_RESET;
    wpos = 0;
    last_t = 0;
    ovf_v = '0;
    cancel_m = '0;
    rep_m = '0;
    foreach (slot_ids[s]) slot_ids[s] = '0;
    foreach (ovf_at[i]) begin
      ovf_at[i] = 0;
      per_of[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset tick of 10 ms.
    add_cmd(OP_QUERY, 0, 500, 0, 0, 0);            // empty and not started
    add_cmd(OP_ADVANCE, 0, 1000, 0, 0, 0);         // advance before start
    add_cmd(OP_ADD, 0, 1000, 1000, 0, 0);          // zero delay: one tick ahead
    add_cmd(OP_ADD, 31, 1000, 900, 1, 0);          // past arrival, repeat with zero period
    add_cmd(OP_ADD, 7, 1000, 1025, 0, 0);          // same slot, fire order by id
    add_cmd(OP_ADD, 3, 1000, 1030, 0, 0);
    add_cmd(OP_ADD, 9, 1000, 1640, 0, 0);          // exactly the wheel range
    add_cmd(OP_ADD, 10, 1000, 1641, 1, 32'hFFFF_FFFF); // just past it: overflow
    add_cmd(OP_ADD, 11, 1000, 1641, 0, 0);         // overflow tie, lower id first
    add_cmd(OP_CANCEL, 7, 1000, 0, 0, 0);
    add_cmd(OP_QUERY, 0, 1004, 0, 0, 0);
    add_cmd(OP_ADVANCE, 0, 1035, 0, 0, 0);
    add_cmd(OP_ADD, 7, 1035, 1050, 0, 0);          // re-add clears the cancel mark
    add_cmd(OP_ADVANCE, 0, 1020, 0, 0, 0);         // clock going back
    add_cmd(OP_QUERY, 0, 1020, 0, 0, 0);
    add_cmd(OP_ADVANCE, 0, 1700, 0, 0, 0);         // more than a wheel of ticks
    add_cmd(OP_QUERY, 0, 1700, 0, 0, 0);
    add_cmd(OP_ADD, 20, 1700, T_MAX, 1, 5);        // top of the time range
    add_cmd(OP_ADVANCE, 0, 2000, 0, 0, 0);
    tnow = 2000;
    drain();

    // Random phases over several tick settings, extremes included.
    random_phase(16'd1, 9, 26);
    random_phase(16'd0, 64, 26);
    random_phase(16'hFFFF, 0, 26);
    random_phase(16'd37, 0, 26);

    // Near the top of time: re-armed arrivals saturate.
    write_tick(16'd10);
    tnow = T_MAX - 3000;
    add_cmd(OP_ADD, 5, tnow, tnow + 5, 1, 32'hFFFF_FFFF);
    add_cmd(OP_ADD, 6, tnow, tnow + 5, 1, 2990);
    add_cmd(OP_ADVANCE, 0, tnow + 20, 0, 0, 0);
    add_cmd(OP_QUERY, 0, tnow + 20, 0, 0, 0);
    add_cmd(OP_ADVANCE, 0, T_MAX, 0, 0, 0);
    add_cmd(OP_QUERY, 0, T_MAX, 0, 0, 0);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
